// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the allocator RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on every rising edge of clk, ignored while rst_n is low.
`define FFSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define FFSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFSA_ASSERT(lbl, prop, msg)
`define FFSA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hw/rtl/ffsa_pkg.sv
// ---------------------------------------------------------------------------
// ffsa_pkg
// Codes and constants of the first-fit segment allocator.
// ---------------------------------------------------------------------------
package ffsa_pkg;

  localparam int ADDR_W = 32;
  localparam int SIZE_W = 24;
  localparam int LEN_W  = 25;
  localparam int CFG_IDX_W = 2;

  localparam logic [ADDR_W-1:0] RESET_BASE   = 32'h0020_0000;
  localparam logic [ADDR_W-1:0] RESET_END    = 32'h0040_0000;
  localparam logic [LEN_W-1:0]  SENTINEL_LEN = 25'd4;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_RESIZE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_NOGAP   = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_ZERO    = 3'd4
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END  = 2'd1;

endpackage

// File: hw/rtl/ffsa_seg_table.sv
// ---------------------------------------------------------------------------
// ffsa_seg_table
// Segment table RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module ffsa_seg_table #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 73
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/ffsa_slot_stack.sv
// ---------------------------------------------------------------------------
// ffsa_slot_stack
// LIFO of free slot numbers, with a low-water mark standing in for the
// initial fill of slots 2 and up.
// ---------------------------------------------------------------------------
module ffsa_slot_stack #(
  parameter int MAX_SEGMENTS = 254
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              init,
  input  logic                              push,
  input  logic [$clog2(MAX_SEGMENTS+2)-1:0] push_slot,
  input  logic                              pop,
  output logic [$clog2(MAX_SEGMENTS+2)-1:0] pop_slot,
  output logic [$clog2(MAX_SEGMENTS+1)-1:0] count
);

  localparam int SW = $clog2(MAX_SEGMENTS + 2);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_SEGMENTS);

  logic [SW-1:0] mem [MAX_SEGMENTS];
  logic [CW-1:0] count_r;
  logic [CW-1:0] lw_r;
  logic [SW-1:0] rd_q;
  logic [SW-1:0] init_q;
  logic          use_init_q;
  logic [CW-1:0] top_idx;

  assign top_idx = count_r - CW'(1);

  // An entry below the low-water mark was never pushed and still holds its
  // initial slot number, which is its index plus two.
  always_ff @(posedge clk) begin
    if (!rst_n || init) begin
      count_r <= FULL_COUNT;
      lw_r    <= FULL_COUNT;
    end else if (push) begin
      count_r <= count_r + CW'(1);
    end else if (pop) begin
      count_r <= top_idx;
      if (top_idx < lw_r) begin
        lw_r <= top_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[count_r[IW-1:0]] <= push_slot;
    end
    if (pop) begin
      rd_q       <= mem[top_idx[IW-1:0]];
      init_q     <= SW'(top_idx) + SW'(2);
      use_init_q <= top_idx < lw_r;
    end
  end

  assign pop_slot = use_init_q ? init_q : rd_q;
  assign count    = count_r;

endmodule

// File: hw/rtl/first_fit_segment_allocator.sv
// ---------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit allocator over a byte region with a linked segment table.
// ---------------------------------------------------------------------------
// Each item is an allocate, free or resize request and yields one result
// item. Segments sit in a RAM with one write and one read port as a linked
// list in address order; each walk step waits on the registered RAM read of
// the next link, which is the loop. An allocate walks from the list head to
// the first gap that fits, and a free walks the list to the segment; a
// resize that must move adds an allocate on top. Requests that end at once
// (zero size, full table, unused action) skip the walk. After reset or a
// configuration write the block writes the two sentinel entries before
// in_ready rises.
module first_fit_segment_allocator
  import ffsa_pkg::*;
#(
  parameter int MAX_SEGMENTS = 254
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic [SIZE_W-1:0]    in_request_size,
  input  logic [ADDR_W-1:0]    in_segment_address,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ADDR_W-1:0]    out_result_address,
  output logic [2:0]           out_status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata
);

`include "assert_macros.svh"

  localparam int SLOTS = MAX_SEGMENTS + 2;
  localparam int SW    = $clog2(SLOTS);
  localparam int CW    = $clog2(MAX_SEGMENTS + 1);
  localparam logic [SW-1:0] BASE_SLOT = SW'(0);
  localparam logic [SW-1:0] END_SLOT  = SW'(1);

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
    logic [SW-1:0]     nxt;
    logic [SW-1:0]     prv;
  } seg_t;

  localparam int EW = $bits(seg_t);

  typedef enum logic [3:0] {
    S_INIT0, S_INIT1, S_IDLE, S_A_RD0, S_A_GOT0, S_A_WALK, S_C_NEW, S_C_NXT,
    S_C_CUR, S_F_WALK, S_U_GOTN, S_U_GOTP, S_U_LINKP, S_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] base_r, end_r;
  logic [1:0]        act_r, act_nxt;
  logic [LEN_W-1:0]  want_r, want_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  seg_t              cur_r, cur_nxt;    // current segment of an allocate walk
  logic [SW-1:0]     cur_idx_r, cur_idx_nxt;
  logic [ADDR_W:0]   cur_lo_r, cur_lo_nxt;
  seg_t              nb_r, nb_nxt;      // neighbor entry: next or previous
  seg_t              te_r, te_nxt;      // segment being freed or resized
  logic [SW-1:0]     t_r, t_nxt;
  logic [SW-1:0]     f_idx_r, f_idx_nxt;
  logic [SW-1:0]     slot_r, slot_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [2:0]        res_st_r, res_st_nxt;
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [2:0]        out_st_r;

  logic              tb_we;
  logic [SW-1:0]     tb_waddr, tb_raddr;
  seg_t              tb_wdata, rd_e;
  logic [EW-1:0]     tb_rdata;

  logic              stk_push, stk_pop, stk_init;
  logic [SW-1:0]     stk_slot;
  logic [CW-1:0]     stk_count;

  logic              cfg_hit;
  logic [LEN_W-1:0]  in_want;
  logic [ADDR_W:0]   lo_sum;
  logic signed [ADDR_W+1:0] gap;
  logic signed [ADDR_W:0]   room;
  logic              gap_fits, room_fits;

  assign cfg_hit = cfg_we && (cfg_index == REG_BASE || cfg_index == REG_END);
  assign rd_e    = seg_t'(tb_rdata);

  // Size rounded up to a multiple of four; 25 bits hold the carry.
  assign in_want = ({1'b0, in_request_size} + LEN_W'(3)) & ~LEN_W'(3);

  // The shared arithmetic: end of the current segment, the gap to the next
  // start, and the room left in place for a resize.
  assign lo_sum   = {1'b0, rd_e.start} + (ADDR_W+1)'(rd_e.len);
  assign gap      = $signed({2'b00, rd_e.start}) - $signed({1'b0, cur_lo_r});
  assign gap_fits = gap >= $signed((ADDR_W+2)'(want_r));
  assign room     = $signed({1'b0, rd_e.start}) - $signed({1'b0, addr_r});
  assign room_fits = room >= $signed((ADDR_W+1)'(want_r));

  assign in_ready = (state_r == S_IDLE);

  ffsa_seg_table #(
    .DEPTH (SLOTS),
    .WIDTH (EW)
  ) u_table (
    .clk   (clk),
    .we    (tb_we),
    .waddr (tb_waddr),
    .wdata (tb_wdata),
    .raddr (tb_raddr),
    .rdata (tb_rdata)
  );

  ffsa_slot_stack #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .init      (stk_init),
    .push      (stk_push),
    .push_slot (t_r),
    .pop       (stk_pop),
    .pop_slot  (stk_slot),
    .count     (stk_count)
  );

  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    want_nxt     = want_r;
    addr_nxt     = addr_r;
    cur_nxt      = cur_r;
    cur_idx_nxt  = cur_idx_r;
    cur_lo_nxt   = cur_lo_r;
    nb_nxt       = nb_r;
    te_nxt       = te_r;
    t_nxt        = t_r;
    f_idx_nxt    = f_idx_r;
    slot_nxt     = slot_r;
    res_addr_nxt = res_addr_r;
    res_st_nxt   = res_st_r;
    tb_we        = 1'b0;
    tb_waddr     = BASE_SLOT;
    tb_wdata     = '0;
    tb_raddr     = BASE_SLOT;
    stk_push     = 1'b0;
    stk_pop      = 1'b0;
    stk_init     = cfg_hit;

    unique case (state_r)
      S_INIT0: begin
        tb_we     = 1'b1;
        tb_waddr  = BASE_SLOT;
        tb_wdata  = '{start: base_r, len: SENTINEL_LEN, nxt: END_SLOT, prv: BASE_SLOT};
        state_nxt = S_INIT1;
      end
      S_INIT1: begin
        tb_we     = 1'b1;
        tb_waddr  = END_SLOT;
        tb_wdata  = '{start: end_r, len: '0, nxt: BASE_SLOT, prv: BASE_SLOT};
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          act_nxt      = in_action;
          want_nxt     = in_want;
          addr_nxt     = in_segment_address;
          res_addr_nxt = '0;
          res_st_nxt   = ST_OK;
          f_idx_nxt    = BASE_SLOT;
          priority if (in_action == ACT_NONE) begin
            state_nxt = S_OUT;
          end else if (in_action != ACT_FREE && in_request_size == '0) begin
            res_st_nxt = ST_ZERO;
            state_nxt  = S_OUT;
          end else if (in_action == ACT_ALLOC) begin
            if (stk_count == '0) begin
              res_st_nxt = ST_FULL;
              state_nxt  = S_OUT;
            end else begin
              state_nxt = S_A_GOT0;
            end
          end else begin
            state_nxt = S_F_WALK;
          end
        end
      end
      S_A_RD0: begin
        // The unlink may just have rewritten the head entry, so it is read
        // again once that write has landed.
        state_nxt = S_A_GOT0;
      end
      S_A_GOT0: begin
        cur_nxt     = rd_e;
        cur_idx_nxt = BASE_SLOT;
        cur_lo_nxt  = lo_sum;
        tb_raddr    = rd_e.nxt;
        state_nxt   = S_A_WALK;
      end
      S_A_WALK: begin
        // Read data is the entry following the current segment.
        priority if (gap_fits) begin
          nb_nxt    = rd_e;
          stk_pop   = 1'b1;
          state_nxt = S_C_NEW;
        end else if (cur_r.nxt == END_SLOT) begin
          res_addr_nxt = '0;
          res_st_nxt   = ST_NOGAP;
          state_nxt    = S_OUT;
        end else begin
          cur_idx_nxt = cur_r.nxt;
          cur_nxt     = rd_e;
          cur_lo_nxt  = lo_sum;
          tb_raddr    = rd_e.nxt;
        end
      end
      S_C_NEW: begin
        slot_nxt  = stk_slot;
        tb_we     = 1'b1;
        tb_waddr  = stk_slot;
        tb_wdata  = '{start: cur_lo_r[ADDR_W-1:0], len: want_r, nxt: cur_r.nxt,
                      prv: cur_idx_r};
        state_nxt = S_C_NXT;
      end
      S_C_NXT: begin
        tb_we        = 1'b1;
        tb_waddr     = cur_r.nxt;
        tb_wdata     = nb_r;
        tb_wdata.prv = slot_r;
        state_nxt    = S_C_CUR;
      end
      S_C_CUR: begin
        tb_we        = 1'b1;
        tb_waddr     = cur_idx_r;
        tb_wdata     = cur_r;
        tb_wdata.nxt = slot_r;
        res_addr_nxt = cur_lo_r[ADDR_W-1:0];
        res_st_nxt   = ST_OK;
        state_nxt    = S_OUT;
      end
      S_F_WALK: begin
        // Starts rise strictly along the list, so the first match is the
        // only one; the sentinels never match.
        priority if (f_idx_r == END_SLOT) begin
          res_st_nxt = ST_UNKNOWN;
          state_nxt  = S_OUT;
        end else if (f_idx_r != BASE_SLOT && rd_e.start == addr_r) begin
          te_nxt    = rd_e;
          t_nxt     = f_idx_r;
          tb_raddr  = rd_e.nxt;
          state_nxt = S_U_GOTN;
        end else begin
          f_idx_nxt = rd_e.nxt;
          tb_raddr  = rd_e.nxt;
        end
      end
      S_U_GOTN: begin
        if (act_r == ACT_RESIZE && room_fits) begin
          tb_we        = 1'b1;
          tb_waddr     = t_r;
          tb_wdata     = te_r;
          tb_wdata.len = want_r;
          res_addr_nxt = addr_r;
          state_nxt    = S_OUT;
        end else begin
          nb_nxt    = rd_e;
          tb_raddr  = te_r.prv;
          state_nxt = S_U_GOTP;
        end
      end
      S_U_GOTP: begin
        tb_we        = 1'b1;
        tb_waddr     = te_r.nxt;
        tb_wdata     = nb_r;
        tb_wdata.prv = te_r.prv;
        nb_nxt       = rd_e;
        state_nxt    = S_U_LINKP;
      end
      S_U_LINKP: begin
        tb_we        = 1'b1;
        tb_waddr     = te_r.prv;
        tb_wdata     = nb_r;
        tb_wdata.nxt = te_r.nxt;
        stk_push     = 1'b1;
        if (act_r == ACT_RESIZE) begin
          // The segment is gone; place the new size from the list head.
          state_nxt = S_A_RD0;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT0;
      end
    endcase

    if (cfg_hit) begin
      state_nxt = S_INIT0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT0;
      base_r      <= RESET_BASE;
      end_r       <= RESET_END;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_index == REG_BASE) begin
        base_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_END) begin
        end_r <= cfg_wdata;
      end
      if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    want_r     <= want_nxt;
    addr_r     <= addr_nxt;
    cur_r      <= cur_nxt;
    cur_idx_r  <= cur_idx_nxt;
    cur_lo_r   <= cur_lo_nxt;
    nb_r       <= nb_nxt;
    te_r       <= te_nxt;
    t_r        <= t_nxt;
    f_idx_r    <= f_idx_nxt;
    slot_r     <= slot_nxt;
    res_addr_r <= res_addr_nxt;
    res_st_r   <= res_st_nxt;
    if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_addr_r <= res_addr_r;
      out_st_r   <= res_st_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_address = out_addr_r;
  assign out_status         = out_st_r;

  `FFSA_ASSERT(a_busy_after_accept, in_valid && in_ready && !cfg_hit |=> !in_ready,
               "allocator ready again right after taking an item")
  `FFSA_ASSERT(a_fail_zero_addr, out_valid && out_status != ST_OK |-> out_result_address == '0,
               "failed request reports a nonzero address")
  `FFSA_ASSERT(a_pop_nonempty, stk_pop |-> stk_count != '0,
               "slot popped from an empty free stack")

endmodule
